// File: rtl/core/chi_pkg.sv
// Shared types, widths and codes for the cubic Hermite segment evaluator.
// No dependencies; imported by every module of the block.
package chi_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned ACC_W         = 64;
    localparam int unsigned T_BITS        = 31;
    localparam int unsigned DIV_STEPS     = 4;
    localparam int unsigned DIV_STAGES    = DATA_W / DIV_STEPS;
    localparam int unsigned HORNER_LAT    = 2;
    localparam int unsigned CFG_IDX_W     = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_SLOPE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_SLOPE   = 3'd5;

    localparam logic [DATA_W-1:0] START_SLOPE_RST = 32'h0001_0000;

    // Region codes
    localparam logic [1:0] REGION_BEFORE = 2'd0;
    localparam logic [1:0] REGION_INSIDE = 2'd1;
    localparam logic [1:0] REGION_BEYOND = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] start_x;
        logic signed [DATA_W-1:0] start_y;
        logic signed [DATA_W-1:0] end_x;
        logic signed [DATA_W-1:0] end_y;
        logic [DATA_W-1:0]        start_slope_mag;
        logic                     start_slope_neg;
        logic [DATA_W-1:0]        end_slope_mag;
        logic                     end_slope_neg;
        logic [DATA_W-1:0]        span_mag;
        logic                     degenerate;
        logic signed [ACC_W-1:0]  p1;
        logic signed [ACC_W-1:0]  q;
        logic signed [ACC_W-1:0]  r;
    } coeff_t;

endpackage

// File: rtl/core/chi_coeff.sv
// Configuration registers and the segment coefficients derived from them.
// Depends on chi_pkg.
module chi_coeff #(
    parameter int unsigned FRAC_BITS = chi_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [chi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [chi_pkg::DATA_W-1:0]     cfg_data,
    output chi_pkg::coeff_t                coeff
);
    import chi_pkg::*;

    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic signed [DATA_W-1:0] start_x_reg, start_y_reg, start_slope_reg;
    logic signed [DATA_W-1:0] end_x_reg, end_y_reg, end_slope_reg;

    // c1
    logic [DATA_W-1:0]        span_mag_reg, sm_mag_reg, em_mag_reg;
    logic                     span_neg_reg, sm_neg_reg, em_neg_reg;
    logic signed [DATA_W:0]   dy1_reg;
    // c2
    logic [ACC_W-1:0]         prod1_reg, prod2_reg;
    logic                     neg1_reg, neg2_reg;
    logic signed [DATA_W:0]   dy2_reg;
    // c3
    logic signed [ACC_W-1:0]  p1_reg, p2_reg;
    logic signed [DATA_W:0]   dy3_reg;
    // c4
    logic signed [ACC_W-1:0]  q_reg, r_reg;

    logic signed [DATA_W:0]   span, dy;
    logic [ACC_W-1:0]         rnd1, rnd2;
    logic signed [ACC_W-1:0]  dy64;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            start_slope_reg <= START_SLOPE_RST;
            end_x_reg       <= '0;
            end_y_reg       <= '0;
            end_slope_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_START_X:     start_x_reg     <= cfg_data;
                REG_START_Y:     start_y_reg     <= cfg_data;
                REG_START_SLOPE: start_slope_reg <= cfg_data;
                REG_END_X:       end_x_reg       <= cfg_data;
                REG_END_Y:       end_y_reg       <= cfg_data;
                REG_END_SLOPE:   end_slope_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign span = $signed({end_x_reg[DATA_W-1], end_x_reg})
                - $signed({start_x_reg[DATA_W-1], start_x_reg});
    assign dy   = $signed({end_y_reg[DATA_W-1], end_y_reg})
                - $signed({start_y_reg[DATA_W-1], start_y_reg});

    assign rnd1 = (prod1_reg + HALF) >> FRAC_BITS;
    assign rnd2 = (prod2_reg + HALF) >> FRAC_BITS;
    assign dy64 = ACC_W'(dy3_reg);

    // Derived coefficients, registered through steps c1 to c4 after any write
    always_ff @(posedge aclk) begin
        span_neg_reg <= span[DATA_W];
        span_mag_reg <= span[DATA_W] ? DATA_W'(-span) : span[DATA_W-1:0];
        sm_neg_reg   <= start_slope_reg[DATA_W-1];
        sm_mag_reg   <= start_slope_reg[DATA_W-1] ? DATA_W'(-start_slope_reg)
                                                  : start_slope_reg;
        em_neg_reg   <= end_slope_reg[DATA_W-1];
        em_mag_reg   <= end_slope_reg[DATA_W-1] ? DATA_W'(-end_slope_reg)
                                                : end_slope_reg;
        dy1_reg      <= dy;

        prod1_reg    <= sm_mag_reg * span_mag_reg;
        prod2_reg    <= em_mag_reg * span_mag_reg;
        neg1_reg     <= sm_neg_reg ^ span_neg_reg;
        neg2_reg     <= em_neg_reg ^ span_neg_reg;
        dy2_reg      <= dy1_reg;

        p1_reg       <= neg1_reg ? -$signed(rnd1) : $signed(rnd1);
        p2_reg       <= neg2_reg ? -$signed(rnd2) : $signed(rnd2);
        dy3_reg      <= dy2_reg;

        q_reg        <= (dy64 <<< 1) + dy64 - (p1_reg <<< 1) - p2_reg;
        r_reg        <= p1_reg + p2_reg - (dy64 <<< 1);
    end

    always_comb begin
        coeff.start_x         = start_x_reg;
        coeff.start_y         = start_y_reg;
        coeff.end_x           = end_x_reg;
        coeff.end_y           = end_y_reg;
        coeff.start_slope_mag = sm_mag_reg;
        coeff.start_slope_neg = sm_neg_reg;
        coeff.end_slope_mag   = em_mag_reg;
        coeff.end_slope_neg   = em_neg_reg;
        coeff.span_mag        = span_mag_reg;
        coeff.degenerate      = (start_x_reg == end_x_reg);
        coeff.p1              = p1_reg;
        coeff.q               = q_reg;
        coeff.r               = r_reg;
    end

endmodule

// File: rtl/core/chi_div_stage.sv
// One stage of the pipelined restoring divider: STEPS quotient bits per stage.
// Depends on chi_pkg.
module chi_div_stage #(
    parameter int unsigned STEPS = chi_pkg::DIV_STEPS
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [chi_pkg::DATA_W-1:0] divisor,
    input  logic [chi_pkg::DATA_W-1:0] rem_in,
    input  logic [chi_pkg::DATA_W-1:0] bits_in,
    input  logic [chi_pkg::DATA_W-1:0] quot_in,
    output logic [chi_pkg::DATA_W-1:0] rem_out,
    output logic [chi_pkg::DATA_W-1:0] bits_out,
    output logic [chi_pkg::DATA_W-1:0] quot_out
);
    import chi_pkg::*;

    logic [DATA_W-1:0] rem_next, bits_next, quot_next;

    always_comb begin
        logic [DATA_W:0] trial;
        rem_next  = rem_in;
        bits_next = bits_in;
        quot_next = quot_in;
        for (int i = 0; i < STEPS; i++) begin
            trial     = {rem_next, bits_next[DATA_W-1]};
            bits_next = bits_next << 1;
            if (trial >= {1'b0, divisor}) begin
                trial     = trial - {1'b0, divisor};
                quot_next = {quot_next[DATA_W-2:0], 1'b1};
            end else begin
                quot_next = {quot_next[DATA_W-2:0], 1'b0};
            end
            rem_next = trial[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_out  <= rem_next;
            bits_out <= bits_next;
            quot_out <= quot_next;
        end
    end

endmodule

// File: rtl/core/chi_horner_step.sv
// One Horner step: acc*t rounded by 2^31, plus addend. Two register stages.
// Depends on chi_pkg.
module chi_horner_step (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [chi_pkg::ACC_W-1:0] acc_in,
    input  logic [chi_pkg::DATA_W-1:0]       t_in,
    input  logic signed [chi_pkg::ACC_W-1:0] addend,
    output logic signed [chi_pkg::ACC_W-1:0] acc_out,
    output logic [chi_pkg::DATA_W-1:0]       t_out
);
    import chi_pkg::*;

    localparam logic [ACC_W-1:0] HALF_T = ACC_W'(1) << (T_BITS - 1);

    logic [ACC_W-1:0]  mag;
    logic [ACC_W-1:0]  prod_hi_reg, prod_lo_reg, rnd;
    logic              neg_reg;
    logic [DATA_W-1:0] t_a_reg;

    assign mag = acc_in[ACC_W-1] ? ACC_W'(-acc_in) : acc_in;
    // high half lands one bit up: 2^32 / 2^31
    assign rnd = (prod_hi_reg << 1) + ((prod_lo_reg + HALF_T) >> T_BITS);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_hi_reg <= mag[ACC_W-1:DATA_W] * t_in;
            prod_lo_reg <= mag[DATA_W-1:0] * t_in;
            neg_reg     <= acc_in[ACC_W-1];
            t_a_reg     <= t_in;
            acc_out     <= addend + (neg_reg ? -$signed(rnd) : $signed(rnd));
            t_out       <= t_a_reg;
        end
    end

endmodule

// File: rtl/core/cubic_hermite_interpolator_unit.sv
// Cubic Hermite segment evaluator, top level. Signed fixed point with FRAC_BITS
// fractional bits. Depends on chi_pkg, chi_coeff, chi_div_stage, chi_horner_step.
//
// Six configuration registers give the segment: start and end abscissa, value
// and slope. Each sample_x transaction yields one result: the region (before
// the start, inside, beyond the end; the segment may run either way), the value
// and a saturation flag. Inside, the block forms t = |x - start_x| / |span| as
// Q1.31 through an 8-stage restoring divider (4 quotient bits per stage) and
// evaluates the cubic in Horner form with three two-stage multiply steps;
// outside, it extrapolates linearly from the nearer endpoint. The pipeline
// takes one transaction per cycle while the output side is not stalled; a
// stall freezes the whole pipeline. Derived coefficients are registered in
// chi_coeff after a configuration write.
module cubic_hermite_interpolator_unit #(
    parameter int unsigned FRAC_BITS = chi_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [chi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [chi_pkg::DATA_W-1:0]        cfg_data,
    // sample channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [chi_pkg::DATA_W-1:0] s_sample_x,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [chi_pkg::DATA_W-1:0] m_value_y,
    output logic [1:0]                        m_region,
    output logic                              m_clipped
);
    import chi_pkg::*;

    // Stage map
    localparam int unsigned S_IN   = 1;                         // sample register
    localparam int unsigned S_CLS  = 2;                         // region, distances
    localparam int unsigned S_DIV0 = 3;                         // divider load, extrap. product
    localparam int unsigned S_EXT  = S_DIV0 + 1;                // extrapolated value
    localparam int unsigned S_T    = S_DIV0 + DIV_STAGES;       // t ready
    localparam int unsigned S_H    = S_T + 3 * HORNER_LAT;      // Horner done
    localparam int unsigned S_OUT  = S_H + 1;                   // output register

    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] Y_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] Y_MIN = -64'sh0000_0000_8000_0000;

    coeff_t coeff;

    logic en;
    logic valid_reg [S_IN:S_OUT];
    logic [1:0] region_reg [S_CLS:S_OUT];
    logic signed [ACC_W-1:0] y_ext_reg [S_EXT:S_H];

    logic signed [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0]        dxs_mag_reg, dxe_mag_reg;
    logic                     dxs_neg_reg, dxe_neg_reg;
    logic [ACC_W-1:0]         ext_prod_reg;
    logic                     ext_neg_reg;
    logic [DATA_W-1:0]        rem0_reg, bits0_reg;
    logic signed [DATA_W-1:0] y_out_reg;
    logic                     clipped_reg;

    logic signed [DATA_W:0]   dxs, dxe;
    logic [1:0]               region_next;
    logic [ACC_W-1:0]         ext_rnd;
    logic signed [ACC_W-1:0]  ext_base, y_full;

    logic [DATA_W-1:0] rem_w  [0:DIV_STAGES-1];
    logic [DATA_W-1:0] bits_w [0:DIV_STAGES-1];
    logic [DATA_W-1:0] quot_w [0:DIV_STAGES];

    logic signed [ACC_W-1:0] acc1, acc2, acc3;
    logic [DATA_W-1:0]       t1, t2;

    // Whole pipeline moves together; holds only while a result waits
    assign en      = !valid_reg[S_OUT] || m_ready;
    assign s_ready = en;

    chi_coeff #(.FRAC_BITS(FRAC_BITS)) u_coeff (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coeff     (coeff)
    );

    // ---- valid and region travel with the data ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = S_IN; k <= S_OUT; k++) valid_reg[k] <= 1'b0;
        end else if (en) begin
            valid_reg[S_IN] <= s_valid;
            for (int k = S_IN + 1; k <= S_OUT; k++) valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            region_reg[S_CLS] <= region_next;
            for (int k = S_CLS + 1; k <= S_OUT; k++) region_reg[k] <= region_reg[k-1];
        end
    end

    // ---- region and distances ----
    assign dxs = $signed({x_reg[DATA_W-1], x_reg})
               - $signed({coeff.start_x[DATA_W-1], coeff.start_x});
    assign dxe = $signed({x_reg[DATA_W-1], x_reg})
               - $signed({coeff.end_x[DATA_W-1], coeff.end_x});

    always_comb begin
        if (coeff.start_x < coeff.end_x) begin
            if (x_reg < coeff.start_x)    region_next = REGION_BEFORE;
            else if (x_reg > coeff.end_x) region_next = REGION_BEYOND;
            else                          region_next = REGION_INSIDE;
        end else begin
            if (x_reg > coeff.start_x)    region_next = REGION_BEFORE;
            else if (x_reg < coeff.end_x) region_next = REGION_BEYOND;
            else                          region_next = REGION_INSIDE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg       <= s_sample_x;
            dxs_neg_reg <= dxs[DATA_W];
            dxs_mag_reg <= dxs[DATA_W] ? DATA_W'(-dxs) : dxs[DATA_W-1:0];
            dxe_neg_reg <= dxe[DATA_W];
            dxe_mag_reg <= dxe[DATA_W] ? DATA_W'(-dxe) : dxe[DATA_W-1:0];
        end
    end

    // ---- linear extrapolation from the nearer endpoint ----
    always_ff @(posedge aclk) begin
        if (en) begin
            if (region_reg[S_CLS] == REGION_BEFORE) begin
                ext_prod_reg <= coeff.start_slope_mag * dxs_mag_reg;
                ext_neg_reg  <= coeff.start_slope_neg ^ dxs_neg_reg;
            end else begin
                ext_prod_reg <= coeff.end_slope_mag * dxe_mag_reg;
                ext_neg_reg  <= coeff.end_slope_neg ^ dxe_neg_reg;
            end
            // dividend = |dx| * 2^31 + |span|/2; no carry between the halves
            rem0_reg  <= {1'b0, dxs_mag_reg[DATA_W-1:1]};
            bits0_reg <= {dxs_mag_reg[0], coeff.span_mag[DATA_W-1:1]};
            y_ext_reg[S_EXT] <= ext_base
                              + (ext_neg_reg ? -$signed(ext_rnd) : $signed(ext_rnd));
            for (int k = S_EXT + 1; k <= S_H; k++) y_ext_reg[k] <= y_ext_reg[k-1];
        end
    end

    assign ext_rnd  = (ext_prod_reg + HALF) >> FRAC_BITS;
    assign ext_base = (region_reg[S_DIV0] == REGION_BEFORE) ? ACC_W'(coeff.start_y)
                                                            : ACC_W'(coeff.end_y);

    // ---- t = round(|dx| * 2^31 / |span|) ----
    assign rem_w[0]  = rem0_reg;
    assign bits_w[0] = bits0_reg;
    assign quot_w[0] = '0;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        if (g < DIV_STAGES - 1) begin : g_mid
            chi_div_stage u_stage (
                .aclk     (aclk),
                .en       (en),
                .divisor  (coeff.span_mag),
                .rem_in   (rem_w[g]),
                .bits_in  (bits_w[g]),
                .quot_in  (quot_w[g]),
                .rem_out  (rem_w[g+1]),
                .bits_out (bits_w[g+1]),
                .quot_out (quot_w[g+1])
            );
        end else begin : g_last
            chi_div_stage u_stage (
                .aclk     (aclk),
                .en       (en),
                .divisor  (coeff.span_mag),
                .rem_in   (rem_w[g]),
                .bits_in  (bits_w[g]),
                .quot_in  (quot_w[g]),
                .rem_out  (),
                .bits_out (),
                .quot_out (quot_w[g+1])
            );
        end
    end

    // ---- Horner: ((r*t + q)*t + p1)*t ----
    chi_horner_step u_horner0 (
        .aclk (aclk), .en (en),
        .acc_in (coeff.r), .t_in (quot_w[DIV_STAGES]), .addend (coeff.q),
        .acc_out (acc1), .t_out (t1)
    );
    chi_horner_step u_horner1 (
        .aclk (aclk), .en (en),
        .acc_in (acc1), .t_in (t1), .addend (coeff.p1),
        .acc_out (acc2), .t_out (t2)
    );
    chi_horner_step u_horner2 (
        .aclk (aclk), .en (en),
        .acc_in (acc2), .t_in (t2), .addend ('0),
        .acc_out (acc3), .t_out ()
    );

    // ---- select, saturate, output register ----
    always_comb begin
        case (region_reg[S_H])
            REGION_INSIDE: begin
                // zero-length segment: the start point itself
                if (coeff.degenerate) y_full = ACC_W'(coeff.start_y);
                else                  y_full = ACC_W'(coeff.start_y) + acc3;
            end
            default: y_full = y_ext_reg[S_H];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (y_full > Y_MAX) begin
                y_out_reg   <= Y_MAX[DATA_W-1:0];
                clipped_reg <= 1'b1;
            end else if (y_full < Y_MIN) begin
                y_out_reg   <= Y_MIN[DATA_W-1:0];
                clipped_reg <= 1'b1;
            end else begin
                y_out_reg   <= y_full[DATA_W-1:0];
                clipped_reg <= 1'b0;
            end
        end
    end

    assign m_valid   = valid_reg[S_OUT];
    assign m_value_y = y_out_reg;
    assign m_region  = region_reg[S_OUT];
    assign m_clipped = clipped_reg;

endmodule

// File: rtl/core/chi_checker.sv
// Port-level checks for the cubic Hermite evaluator, bound to the top level.
// Depends on chi_pkg and cubic_hermite_interpolator_unit.
module chi_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [chi_pkg::DATA_W-1:0] m_value_y,
    input logic [1:0]                        m_region,
    input logic                              m_clipped
);
    import chi_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_y)
                                && $stable(m_region) && $stable(m_clipped))
        else $error("result changed while stalled");

    // with no result pending the block always takes a transaction
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input refused with empty output");

    a_region: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_region == REGION_BEFORE || m_region == REGION_INSIDE
                     || m_region == REGION_BEYOND))
        else $error("illegal region code");

    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clipped |-> (m_value_y == 32'sh7FFF_FFFF
                                  || m_value_y == 32'sh8000_0000))
        else $error("clipped result not at a rail");

endmodule

bind cubic_hermite_interpolator_unit chi_checker u_chi_checker (.*);
